>>> design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sparse set tile store
// Status codes, field widths and the command and status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int KEYS_DEFAULT = 4096;

  localparam logic [12:0] KEY_COUNT_RESET = 13'd4096;

  localparam logic [2:0] ST_INSERTED     = 3'd0;
  localparam logic [2:0] ST_UPDATED      = 3'd1;
  localparam logic [2:0] ST_UNCHANGED    = 3'd2;
  localparam logic [2:0] ST_REMOVED      = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;
  localparam logic [2:0] ST_ABSENT       = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       clr_wr;
    logic       insert;
    logic       reject;
    logic [2:0] reject_code;
    logic       upd_read;
    logic       upd_write;
    logic       rem;
    logic       move;
  } sst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_remove;
    logic in_range;
    logic hit;
    logic count_zero;
    logic count_full;
    logic rem_same;
    logic clr_done;
  } sst_stat_t;

endpackage

>>> design/sparse_set_tile_store.sv
// ----------------------------------------------------------------------------
// sparse_set_tile_store: sparse set of tile entries with swap-remove
// A key map points into a packed array of tile entries; remove fills the
// hole with the last entry.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, key and the tile fields with start high; the
//   command transfers at a clock edge where start is high and busy is low.
//   Result channel: done is high for one cycle with status, slot and
//   stored_count; the receiver takes it in that cycle and cannot stall it.
//   Configuration: cfg_write with cfg_data sets key_count; write only while
//   busy is low and no result is pending.
// Steps (transfer edge to the edge that takes the result):
//   insert, rejected command, remove of the last entry: map read, then result
//   update or unchanged, remove with a move: map read, entry read, then write-back
//   The map memory read, then the entry memory read and the write-backs
//   through single write ports set these steps. busy drops as done rises,
//   so the next command can transfer while a result is shown.
// Reset: rst clears the count and restores key_count to 4096, then the map
//   is cleared one key per cycle while busy stays high.
// ----------------------------------------------------------------------------
module sparse_set_tile_store import sst_pkg::*; #(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [11:0]        key,
  input  logic signed [15:0] grid_x,
  input  logic signed [15:0] grid_y,
  input  logic [15:0]        atlas_x,
  input  logic [15:0]        atlas_y,
  input  logic [15:0]        atlas_height,
  input  logic               cfg_write,
  input  logic [12:0]        cfg_data,
  output logic               done,
  output logic [2:0]         status,
  output logic [11:0]        slot,
  output logic [12:0]        stored_count
);

  sst_cmd_t  cmd;
  sst_stat_t stat;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sst_datapath #(
    .KEYS (KEYS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .key          (key),
    .grid_x       (grid_x),
    .grid_y       (grid_y),
    .atlas_x      (atlas_x),
    .atlas_y      (atlas_y),
    .atlas_height (atlas_height),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .stored_count (stored_count)
  );

endmodule

>>> design/sst_datapath.sv
// ----------------------------------------------------------------------------
// sst_datapath: key map, dense entry memory and result registers
// Holds the key-to-slot map (valid bit plus slot), the packed entry array
// (key, grid, atlas), the entry count and the key_count register.
// ----------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; #(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  sst_cmd_t           cmd,
  output sst_stat_t          stat,
  input  logic               op,
  input  logic [11:0]        key,
  input  logic signed [15:0] grid_x,
  input  logic signed [15:0] grid_y,
  input  logic [15:0]        atlas_x,
  input  logic [15:0]        atlas_y,
  input  logic [15:0]        atlas_height,
  input  logic               cfg_write,
  input  logic [12:0]        cfg_data,
  output logic               done,
  output logic [2:0]         status,
  output logic [11:0]        slot,
  output logic [12:0]        stored_count
);

  localparam int AW = $clog2(KEYS);
  localparam int CW = $clog2(KEYS + 1);
  localparam int EW = AW + 80;

  logic [AW:0]   map_mem [KEYS];
  logic [EW-1:0] ent_mem [KEYS];

  logic [12:0]   key_count;
  logic          op_q;
  logic [11:0]   key_q;
  logic [31:0]   grid_q;
  logic [47:0]   atlas_q;
  logic [AW:0]   map_q;
  logic [EW-1:0] ent_q;
  logic [AW-1:0] slot_q;
  logic [CW-1:0] count;
  logic [AW-1:0] clr_cnt;

  logic [CW-1:0] count_next;
  logic [AW-1:0] kidx;
  logic [AW-1:0] map_slot;
  logic [AW-1:0] last;
  logic [AW-1:0] cnt_idx;
  logic [AW-1:0] ent_key;
  logic [31:0]   ent_grid;
  logic [47:0]   ent_atlas;
  logic          same;

  logic          map_we;
  logic [AW-1:0] map_wa;
  logic [AW:0]   map_wd;
  logic          ent_we;
  logic [AW-1:0] ent_wa;
  logic [EW-1:0] ent_wd;
  logic          ent_re;
  logic [AW-1:0] ent_ra;

  logic          emit;
  logic [2:0]    emit_code;
  logic [AW-1:0] emit_slot;

  assign kidx      = AW'(key_q);
  assign map_slot  = map_q[AW-1:0];
  assign last      = AW'(count - CW'(1));
  assign cnt_idx   = AW'(count);
  assign ent_key   = ent_q[EW-1 -: AW];
  assign ent_grid  = ent_q[79:48];
  assign ent_atlas = ent_q[47:0];
  // height is not part of the match
  assign same      = (ent_grid == grid_q) && (ent_atlas[31:0] == atlas_q[31:0]);

  assign stat.op_remove  = op_q;
  assign stat.in_range   = (13'(key_q) < key_count) && (32'(key_q) < 32'(KEYS));
  assign stat.hit        = map_q[AW];
  assign stat.count_zero = (count == '0);
  assign stat.count_full = (32'(count) >= 32'(KEYS));
  assign stat.rem_same   = (map_slot == last);
  assign stat.clr_done   = (clr_cnt == AW'(KEYS - 1));

  always_comb begin
    map_we = 1'b0;
    map_wa = kidx;
    map_wd = '0;
    if (cmd.clr_wr) begin
      map_we = 1'b1;
      map_wa = clr_cnt;
    end else if (cmd.insert) begin
      map_we = 1'b1;
      map_wd = {1'b1, cnt_idx};
    end else if (cmd.rem) begin
      map_we = 1'b1;
    end else if (cmd.move) begin
      // repoint the key of the entry that fills the hole
      map_we = 1'b1;
      map_wa = ent_key;
      map_wd = {1'b1, slot_q};
    end
  end

  always_comb begin
    ent_we = 1'b0;
    ent_wa = cnt_idx;
    ent_wd = {kidx, grid_q, atlas_q};
    if (cmd.insert) begin
      ent_we = 1'b1;
    end else if (cmd.upd_write && !same) begin
      ent_we = 1'b1;
      ent_wa = slot_q;
      ent_wd = {ent_key, grid_q, atlas_q};
    end else if (cmd.move) begin
      ent_we = 1'b1;
      ent_wa = slot_q;
      ent_wd = ent_q;
    end
  end

  assign ent_re = cmd.upd_read | cmd.rem;
  assign ent_ra = cmd.upd_read ? map_slot : last;

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_code = ST_INSERTED;
    emit_slot = '0;
    if (cmd.reject) begin
      emit      = 1'b1;
      emit_code = cmd.reject_code;
    end else if (cmd.insert) begin
      emit      = 1'b1;
      emit_slot = cnt_idx;
    end else if (cmd.upd_write) begin
      emit      = 1'b1;
      emit_code = same ? ST_UNCHANGED : ST_UPDATED;
      emit_slot = slot_q;
    end else if (cmd.rem && stat.rem_same) begin
      emit      = 1'b1;
      emit_code = ST_REMOVED;
      emit_slot = map_slot;
    end else if (cmd.move) begin
      emit      = 1'b1;
      emit_code = ST_REMOVED;
      emit_slot = slot_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      count     <= '0;
      clr_cnt   <= '0;
      key_count <= KEY_COUNT_RESET;
    end else begin
      done  <= emit;
      count <= count_next;
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cfg_write) begin
        key_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      key_q   <= key;
      grid_q  <= {grid_y, grid_x};
      atlas_q <= {atlas_height, atlas_y, atlas_x};
    end
    if (cmd.upd_read || cmd.rem) begin
      slot_q <= map_slot;
    end
    if (emit) begin
      status       <= emit_code;
      slot         <= 12'(emit_slot);
      stored_count <= 13'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd.capture) begin
      map_q <= map_mem[AW'(key)];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_ra];
    end
  end

endmodule

>>> design/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: sequencer of the sparse set tile store
// Runs the map clearing pass after reset, then steps each accepted command
// through map lookup and, where needed, entry read and write-back.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sst_stat_t stat,
  output sst_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_UPD,
    S_MOVE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        if (!stat.in_range) begin
          cmd.reject      = 1'b1;
          cmd.reject_code = ST_OUT_OF_RANGE;
        end else if (!stat.op_remove) begin
          if (stat.hit) begin
            cmd.upd_read = 1'b1;
            state_next   = S_UPD;
          end else if (stat.count_full) begin
            cmd.reject      = 1'b1;
            cmd.reject_code = ST_OUT_OF_RANGE;
          end else begin
            cmd.insert = 1'b1;
          end
        end else if (!stat.hit || stat.count_zero) begin
          cmd.reject      = 1'b1;
          cmd.reject_code = ST_ABSENT;
        end else begin
          // removing the last entry needs no move
          cmd.rem = 1'b1;
          if (!stat.rem_same) begin
            state_next = S_MOVE;
          end
        end
      end
      S_UPD: begin
        cmd.upd_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

>>> design/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level checks of the sparse set tile store
// Watches command and result ports over time; attached by bind.
// ----------------------------------------------------------------------------
module sst_checker import sst_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [2:0]         status,
  input logic [11:0]        slot
);

  // a transferred command makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command transfer not followed by busy");

  // results show only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // one result per command, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_INSERTED || status == ST_UPDATED ||
              status == ST_UNCHANGED || status == ST_REMOVED ||
              status == ST_OUT_OF_RANGE || status == ST_ABSENT))
    else $error("undefined status code");

  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OUT_OF_RANGE || status == ST_ABSENT) |-> slot == 12'd0)
    else $error("ignored command reports a nonzero slot");

endmodule

bind sparse_set_tile_store sst_checker u_sst_checker (.*);

>>> tb/sst_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_tb_pkg: command codes for the tile store testbench
// Operation codes that the stimulus and the result checker share.
// ----------------------------------------------------------------------------
package sst_tb_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

endpackage

>>> tb/sparse_set_tile_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_tile_store_checker: scoreboard for the sparse set tile store
// Watches the command, configuration and result channels, keeps its own
// copy of the key map and the packed entry array, and compares every result
// field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sparse_set_tile_store_checker #(
  parameter int KEYS = sst_pkg::KEYS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               op,
  input  logic [11:0]        key,
  input  logic signed [15:0] grid_x,
  input  logic signed [15:0] grid_y,
  input  logic [15:0]        atlas_x,
  input  logic [15:0]        atlas_y,
  input  logic [15:0]        atlas_height,
  input  logic               cfg_write,
  input  logic [12:0]        cfg_data,
  input  logic               done,
  input  logic [2:0]         status,
  input  logic [11:0]        slot,
  input  logic [12:0]        stored_count,
  output int                 fail_count,
  output int                 pending
);
  import sst_pkg::*;
  import sst_tb_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [12:0] count;
  } tile_result_t;

  logic        key_live    [KEYS];
  logic [11:0] key_slot    [KEYS];
  logic [11:0] entry_key   [KEYS];
  logic [31:0] entry_grid  [KEYS];
  logic [47:0] entry_atlas [KEYS];
  logic [12:0] entry_total;
  logic [12:0] key_limit;

  tile_result_t expected_results[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("%0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  // Apply one command to the shadow store and return the result it yields.
  function automatic tile_result_t predict_tile_op(input logic opv, input logic [11:0] k,
                                                   input logic [31:0] grid,
                                                   input logic [47:0] atlas);
    logic [11:0]  s;
    logic [11:0]  last;
    logic [11:0]  moved;
    tile_result_t r;
    r.slot = '0;
    if ({1'b0, k} >= key_limit || int'(k) >= KEYS) begin
      r.status = ST_OUT_OF_RANGE;
    end else if (opv == OP_ADD) begin
      if (!key_live[k]) begin
        s              = entry_total[11:0];
        key_live[k]    = 1'b1;
        key_slot[k]    = s;
        entry_key[s]   = k;
        entry_grid[s]  = grid;
        entry_atlas[s] = atlas;
        entry_total    = entry_total + 13'd1;
        r.status       = ST_INSERTED;
        r.slot         = s;
      end else begin
        s      = key_slot[k];
        r.slot = s;
        // height does not take part in the comparison
        if (entry_grid[s] == grid && entry_atlas[s][31:0] == atlas[31:0]) begin
          r.status = ST_UNCHANGED;
        end else begin
          entry_grid[s]  = grid;
          entry_atlas[s] = atlas;
          r.status       = ST_UPDATED;
        end
      end
    end else if (!key_live[k] || entry_total == 13'd0) begin
      r.status = ST_ABSENT;
    end else begin
      s    = key_slot[k];
      last = entry_total[11:0] - 12'd1;
      // fill the hole with the last entry and repoint its key
      if (s != last) begin
        moved           = entry_key[last];
        entry_key[s]    = entry_key[last];
        entry_grid[s]   = entry_grid[last];
        entry_atlas[s]  = entry_atlas[last];
        key_slot[moved] = s;
      end
      key_live[k] = 1'b0;
      key_slot[k] = '0;
      entry_total = entry_total - 13'd1;
      r.status    = ST_REMOVED;
      r.slot      = s;
    end
    r.count = entry_total;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tile_result_t want;
    tile_result_t predicted;
    if (rst) begin
      foreach (key_live[i]) begin
        key_live[i] = 1'b0;
        key_slot[i] = '0;
      end
      entry_total = '0;
      key_limit   = KEY_COUNT_RESET;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d slot %0d count %0d",
                                    status, slot, stored_count));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status: got %0d, expected %0d", status, want.status));
          if (slot !== want.slot)
            report_mismatch($sformatf("slot: got %0d, expected %0d", slot, want.slot));
          if (stored_count !== want.count)
            report_mismatch($sformatf("stored_count: got %0d, expected %0d",
                                      stored_count, want.count));
        end
      end
      if (cfg_write) begin
        key_limit = cfg_data;
      end
      if (start && !busy) begin
        predicted = predict_tile_op(op, key, {grid_y, grid_x},
                                    {atlas_height, atlas_y, atlas_x});
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sparse_set_tile_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_tile_store_test: top of the tile store testbench
// Drives a directed sequence of inserts, updates and swap-removes, then
// random command traffic in bursts over several key_count settings; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sparse_set_tile_store_test;
  import sst_pkg::*;
  import sst_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 70;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic               op           = OP_ADD;
  logic [11:0]        key          = '0;
  logic signed [15:0] grid_x       = '0;
  logic signed [15:0] grid_y       = '0;
  logic [15:0]        atlas_x      = '0;
  logic [15:0]        atlas_y      = '0;
  logic [15:0]        atlas_height = '0;
  logic               cfg_write    = 1'b0;
  logic [12:0]        cfg_data     = '0;
  logic               busy;
  logic               done;
  logic [2:0]         status;
  logic [11:0]        slot;
  logic [12:0]        stored_count;

  int fail_count;
  int pending;
  int stall_cycles = 0;

  // last position sent per key, replayed to hit the unchanged case
  bit [31:0] sent_grid  [4096];
  bit [47:0] sent_atlas [4096];

  always #6 clk = ~clk;

  sparse_set_tile_store uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key          (key),
    .grid_x       (grid_x),
    .grid_y       (grid_y),
    .atlas_x      (atlas_x),
    .atlas_y      (atlas_y),
    .atlas_height (atlas_height),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .stored_count (stored_count)
  );

  sparse_set_tile_store_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key          (key),
    .grid_x       (grid_x),
    .grid_y       (grid_y),
    .atlas_x      (atlas_x),
    .atlas_y      (atlas_y),
    .atlas_height (atlas_height),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .stored_count (stored_count),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Present one command and return at the edge where it transfers.
  task automatic send_tile(input logic opv, input logic [11:0] k, input logic [15:0] gx,
                           input logic [15:0] gy, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] ah);
    logic was_busy;
    op           <= opv;
    key          <= k;
    grid_x       <= gx;
    grid_y       <= gy;
    atlas_x      <= ax;
    atlas_y      <= ay;
    atlas_height <= ah;
    start        <= 1'b1;
    if (opv == OP_ADD) begin
      sent_grid[k]  = {gy, gx};
      sent_atlas[k] = {ah, ay, ax};
    end
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy !== 1'b0);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold until every expected result has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic write_key_limit(input logic [12:0] limit);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_tile(input int limit);
    int          pick;
    int          span;
    logic        opv;
    logic [11:0] k;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] ax;
    logic [15:0] ay;
    span = (limit < 24) ? limit : 24;
    pick = $urandom_range(0, 99);
    // mostly a small pool at both ends of the key range, so keys collide
    if (pick < 40) k = 12'($urandom_range(0, span - 1));
    else if (pick < 75) k = 12'(limit - 1 - $urandom_range(0, span - 1));
    else if (pick < 88) k = (limit > 4095) ? 12'd4095 : 12'(limit);
    else k = 12'($urandom_range(0, 4095));
    opv = ($urandom_range(0, 9) < 6) ? OP_ADD : OP_REMOVE;
    gx  = 16'($urandom);
    gy  = 16'($urandom);
    ax  = 16'($urandom);
    ay  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      {gy, gx} = sent_grid[k];
      {ay, ax} = sent_atlas[k][31:0];
      // change a single field now and then
      if (pick < 15) begin
        case ($urandom_range(0, 3))
          0: gx = 16'($urandom);
          1: gy = 16'($urandom);
          2: ax = 16'($urandom);
          default: ay = 16'($urandom);
        endcase
      end
    end
    send_tile(opv, k, gx, gy, ax, ay, 16'($urandom));
  endtask

  initial begin
    int phase_limit;
    int burst_left;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    // directed: inserts at the field extremes, update, unchanged, swap-remove
    send_tile(OP_REMOVE, 12'd7,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_ADD,    12'd0,    16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000);
    send_tile(OP_ADD,    12'd4095, 16'h7fff, 16'h8000, 16'hffff, 16'h0000, 16'hffff);
    send_tile(OP_ADD,    12'd0,    16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'hffff);
    send_tile(OP_ADD,    12'd0,    16'hffff, 16'h7fff, 16'h0000, 16'hffff, 16'h1234);
    send_tile(OP_ADD,    12'd0,    16'hffff, 16'h7fff, 16'h0000, 16'h1234, 16'h1234);
    send_tile(OP_ADD,    12'd100,  16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005);
    send_tile(OP_ADD,    12'd200,  16'h00aa, 16'h00bb, 16'h00cc, 16'h00dd, 16'h00ee);
    send_tile(OP_REMOVE, 12'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_ADD,    12'd200,  16'h00aa, 16'h00bb, 16'h00cc, 16'h00dd, 16'h5555);
    send_tile(OP_REMOVE, 12'd200,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_REMOVE, 12'd4095, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_REMOVE, 12'd100,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_REMOVE, 12'd100,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_ADD,    12'd4095, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555);
    // shrink the key range: the stored high key stays counted but unreachable
    write_key_limit(13'd1);
    send_tile(OP_ADD,    12'd0,    16'h0f0f, 16'hf0f0, 16'h0ff0, 16'hf00f, 16'h0000);
    send_tile(OP_ADD,    12'd1,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_REMOVE, 12'd4095, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_ADD,    12'd4095, 16'h9999, 16'h9999, 16'h9999, 16'h9999, 16'h9999);
    write_key_limit(13'd4096);
    send_tile(OP_REMOVE, 12'd4095, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tile(OP_REMOVE, 12'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: phase_limit = 64;
        1: phase_limit = 4096;
        2: phase_limit = 1;
        3: phase_limit = 12;
        4: phase_limit = 4095;
        5: phase_limit = 2;
        6: phase_limit = $urandom_range(1, 4096);
        default: phase_limit = 600;
      endcase
      write_key_limit(phase_limit[12:0]);
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) drain();
        random_tile(phase_limit);
        burst_left--;
        if (burst_left == 0) begin
          // one phase skips the hold-off between bursts
          if (phase != 4) hold_off($urandom_range(1, 5));
          burst_left = $urandom_range(1, 16);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Count cycles with no transfer on either channel.
  always @(negedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

>>> sparse_set_tile_store.f
design/sst_pkg.sv
design/sst_datapath.sv
design/sst_ctrl.sv
design/sparse_set_tile_store.sv
design/sst_checker.sv
tb/sst_tb_pkg.sv
tb/sparse_set_tile_store_checker.sv
tb/sparse_set_tile_store_test.sv
